[rtl/touch_gesture_classifier_defines.svh]
// assertion macros used by touch_gesture_classifier.sv
`ifndef TOUCH_GESTURE_CLASSIFIER_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TGC_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define TGC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TGC_ASSERT_IMPL(name, clk, rst, ante, cons)
`define TGC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

[rtl/tgc_pkg.sv]
`default_nettype none

package tgc_pkg;

   // fixed field widths
   localparam int STAMP_W     = 32;
   localparam int TIME_W      = 16;
   localparam int RADIUS_W    = 12;
   localparam int POS_W       = 12;
   localparam int CNT_W       = 4;
   localparam int DELTA_W     = 16;
   localparam int VEL_W       = 21;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 64;

   localparam int VEL_MAX = 1048575;

   localparam logic [CNT_W-1:0] CNT_MAX       = 4'd15;
   localparam logic [CNT_W-1:0] PINCH_FINGERS = 4'd2;

   // register reset values
   localparam logic [TIME_W-1:0]   TAP_TIME_RST   = 16'd250;
   localparam logic [RADIUS_W-1:0] TAP_RADIUS_RST = 12'd5;
   localparam logic [RADIUS_W-1:0] SWIPE_MIN_RST  = 12'd20;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TAP_TIME   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_RADIUS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SWIPE_MIN  = 2'd2;

   typedef enum logic [1:0] {
      FUNC_DOWN   = 2'd0,
      FUNC_MOTION = 2'd1,
      FUNC_UP     = 2'd2,
      FUNC_MULTI  = 2'd3
   } tgc_func_type;

   typedef enum logic [1:0] {
      G_TAP   = 2'd0,
      G_HOLD  = 2'd1,
      G_SWIPE = 2'd2,
      G_PINCH = 2'd3
   } tgc_gesture_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_CALC = 4'b0100,
      S_DONE = 4'b1000
   } tgc_state_type;

   // divider control from the sequencer
   typedef struct packed {
      logic load;
      logic neg;
   } tgc_div_ctrl_type;

endpackage

`default_nettype wire

[rtl/tgc_vel_div.sv]
`default_nettype none

// restoring divider, one quotient bit per cycle, with saturation and sign
module tgc_vel_div #(
   parameter int NUM_W = 20
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire  tgc_pkg::tgc_div_ctrl_type        ctrl,
   input  wire        [NUM_W-1:0]                 num,
   input  wire        [tgc_pkg::STAMP_W-1:0]      divisor,
   output logic                                   done,
   output logic signed [tgc_pkg::VEL_W-1:0]       vel
);
   import tgc_pkg::*;

   localparam int DCNT_W = $clog2(NUM_W + 1);
   localparam int SAT_W  = (NUM_W > VEL_W) ? NUM_W : VEL_W;

   logic [DCNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [STAMP_W-1:0] rem_ff, rem_in;
   logic [STAMP_W-1:0] div_ff, div_in;
   logic               neg_ff, neg_in;

   logic [STAMP_W:0]   trial;
   logic [STAMP_W:0]   diff;
   logic               fits;
   logic [SAT_W-1:0]   q_ext;
   logic [VEL_W-1:0]   mag;

   // one trial subtraction
   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = trial >= {1'b0, div_ff};
   end

   // next state
   always_comb begin
      cnt_in = cnt_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      if (ctrl.load) begin
         cnt_in = DCNT_W'(NUM_W);
         num_in = num;
         rem_in = '0;
         div_in = divisor;
         neg_in = ctrl.neg;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         num_in = {num_ff[NUM_W-2:0], fits};
         rem_in = fits ? diff[STAMP_W-1:0] : trial[STAMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   // saturate the quotient and apply the sign
   always_comb begin
      q_ext = SAT_W'(num_ff);
      if (q_ext > SAT_W'(VEL_MAX)) begin
         mag = VEL_W'(VEL_MAX);
      end else begin
         mag = VEL_W'(q_ext);
      end
      vel  = neg_ff ? -$signed(mag) : $signed(mag);
      done = (cnt_ff == '0);
   end

endmodule

`default_nettype wire

[rtl/touch_gesture_classifier.sv]
// touch gesture classifier
//
// req channel: one touch event per request, kind in req_tuser, the rest in
// req_tdata. rsp channel: zero or one gesture per request, kind in
// rsp_tuser. csr channel: register writes, always ready, applied at once;
// write only while no request is in flight.
//
// one request is worked on at a time. finger-down, motion and multigesture
// pass through the exec state; a result (if any) then waits in the done state
// until it is loaded into the output register. a finger-up with an active
// touch runs the squared distances (one multiplier bit per cycle) and the
// two velocity dividers (one quotient bit per cycle) side by side, and the
// sequencer classifies the touch once both the squaring and the dividers are through.
//
// the output register frees req_tready while a result waits; a following
// result waits in the sequencer until rsp_tready takes the earlier one.
// reset clears the touch state, the finger count, any pending result and
// returns the registers to their defaults.
`default_nettype none
`include "touch_gesture_classifier_defines.svh"

module touch_gesture_classifier #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 8
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // request: tdata = pos_x, pos_y, stamp_ms, finger_total, pinch_delta, zero pad
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [tgc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // request: tuser = func
   input  wire  [1:0]                          req_tuser,
   // response: tdata = vel_x, vel_y, pinch_amount, held_count, zero pad
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [tgc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // response: tuser = gesture
   output logic [1:0]                          rsp_tuser,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [tgc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [tgc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import tgc_pkg::*;

   localparam int SQ_W     = (COORD_BITS > RADIUS_W) ? COORD_BITS : RADIUS_W;
   localparam int PROD_W   = 2 * SQ_W;
   localparam int D2_W     = PROD_W + 1;
   localparam int NUM_W    = COORD_BITS + FRAC_BITS;
   localparam int SQCNT_W  = $clog2(SQ_W + 1);

   tgc_state_type          state_ff, state_in;

   // captured request
   tgc_func_type           func_ff, func_in;
   logic [COORD_BITS-1:0]  px_ff, px_in;
   logic [COORD_BITS-1:0]  py_ff, py_in;
   logic [STAMP_W-1:0]     stamp_ff, stamp_in;
   logic [CNT_W-1:0]       fingers_ff, fingers_in;
   logic [DELTA_W-1:0]     delta_ff, delta_in;

   // registers
   logic [TIME_W-1:0]      tap_time_ff, tap_time_in;
   logic [RADIUS_W-1:0]    tap_radius_ff, tap_radius_in;
   logic [RADIUS_W-1:0]    swipe_min_ff, swipe_min_in;

   // touch state
   logic                   touch_active_ff, touch_active_in;
   logic [COORD_BITS-1:0]  start_px_ff, start_px_in;
   logic [COORD_BITS-1:0]  start_py_ff, start_py_in;
   logic [STAMP_W-1:0]     start_stamp_ff, start_stamp_in;
   logic [CNT_W-1:0]       finger_count_ff, finger_count_in;

   // serial squaring
   logic                   short_ff, short_in;
   logic [SQCNT_W-1:0]     sq_cnt_ff, sq_cnt_in;
   logic [SQ_W-1:0]        mx_ff, mx_in, my_ff, my_in, mr_ff, mr_in, ms_ff, ms_in;
   logic [PROD_W-1:0]      ax_ff, ax_in, ay_ff, ay_in, ar_ff, ar_in, as_ff, as_in;
   logic [D2_W-1:0]        d2_ff, d2_in;
   logic [PROD_W-1:0]      r2_ff, r2_in;
   logic [PROD_W-1:0]      s2_ff, s2_in;

   tgc_gesture_type        res_g_ff, res_g_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   tgc_gesture_type        rsp_gesture_ff, rsp_gesture_in;
   logic [VEL_W-1:0]       rsp_vel_x_ff, rsp_vel_x_in;
   logic [VEL_W-1:0]       rsp_vel_y_ff, rsp_vel_y_in;
   logic [DELTA_W-1:0]     rsp_pinch_ff, rsp_pinch_in;
   logic [CNT_W-1:0]       rsp_held_ff, rsp_held_in;

   logic [STAMP_W-1:0]     elapsed;
   logic                   is_short;
   logic                   is_long;
   logic [STAMP_W-1:0]     divisor;
   logic [COORD_BITS-1:0]  dx, dy;
   logic                   neg_x, neg_y;
   logic                   req_fire;
   logic                   slot_free;

   tgc_div_ctrl_type       div_ctrl_x, div_ctrl_y;
   logic                   div_done_x, div_done_y;
   logic signed [VEL_W-1:0] vel_x, vel_y;

   // time and distance of the captured event against the stored start
   always_comb begin
      elapsed  = stamp_ff - start_stamp_ff;
      is_short = elapsed < STAMP_W'(tap_time_ff);
      is_long  = elapsed > STAMP_W'(tap_time_ff);
      divisor  = (elapsed == '0) ? STAMP_W'(1) : elapsed;
      neg_x    = px_ff < start_px_ff;
      neg_y    = py_ff < start_py_ff;
      dx       = neg_x ? (start_px_ff - px_ff) : (px_ff - start_px_ff);
      dy       = neg_y ? (start_py_ff - py_ff) : (py_ff - start_py_ff);
   end

   // velocity dividers, loaded on a finger-up with an active touch
   always_comb begin
      div_ctrl_x.load = (state_ff == S_EXEC) && (func_ff == FUNC_UP) && touch_active_ff;
      div_ctrl_x.neg  = neg_x;
      div_ctrl_y.load = div_ctrl_x.load;
      div_ctrl_y.neg  = neg_y;
   end

   tgc_vel_div #(
      .NUM_W (NUM_W)
   ) u_div_x (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (div_ctrl_x),
      .num     (NUM_W'(dx) << FRAC_BITS),
      .divisor (divisor),
      .done    (div_done_x),
      .vel     (vel_x)
   );

   tgc_vel_div #(
      .NUM_W (NUM_W)
   ) u_div_y (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (div_ctrl_y),
      .num     (NUM_W'(dy) << FRAC_BITS),
      .divisor (divisor),
      .done    (div_done_y),
      .vel     (vel_y)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // sequencer and datapath next state
   always_comb begin
      state_in        = state_ff;
      func_in         = func_ff;
      px_in           = px_ff;
      py_in           = py_ff;
      stamp_in        = stamp_ff;
      fingers_in      = fingers_ff;
      delta_in        = delta_ff;
      tap_time_in     = tap_time_ff;
      tap_radius_in   = tap_radius_ff;
      swipe_min_in    = swipe_min_ff;
      touch_active_in = touch_active_ff;
      start_px_in     = start_px_ff;
      start_py_in     = start_py_ff;
      start_stamp_in  = start_stamp_ff;
      finger_count_in = finger_count_ff;
      short_in        = short_ff;
      sq_cnt_in       = sq_cnt_ff;
      mx_in           = mx_ff;
      my_in           = my_ff;
      mr_in           = mr_ff;
      ms_in           = ms_ff;
      ax_in           = ax_ff;
      ay_in           = ay_ff;
      ar_in           = ar_ff;
      as_in           = as_ff;
      d2_in           = d2_ff;
      r2_in           = r2_ff;
      s2_in           = s2_ff;
      res_g_in        = res_g_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_gesture_in  = rsp_gesture_ff;
      rsp_vel_x_in    = rsp_vel_x_ff;
      rsp_vel_y_in    = rsp_vel_y_ff;
      rsp_pinch_in    = rsp_pinch_ff;
      rsp_held_in     = rsp_held_ff;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            REG_TAP_TIME:   tap_time_in   = csr_data[TIME_W-1:0];
            REG_TAP_RADIUS: tap_radius_in = csr_data[RADIUS_W-1:0];
            REG_SWIPE_MIN:  swipe_min_in  = csr_data[RADIUS_W-1:0];
            default: ;
         endcase
      end

      // response taken
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               func_in    = tgc_func_type'(req_tuser);
               px_in      = COORD_BITS'(req_tdata[POS_W-1:0]);
               py_in      = COORD_BITS'(req_tdata[2*POS_W-1:POS_W]);
               stamp_in   = req_tdata[2*POS_W+STAMP_W-1:2*POS_W];
               fingers_in = req_tdata[2*POS_W+STAMP_W+CNT_W-1:2*POS_W+STAMP_W];
               delta_in   = req_tdata[2*POS_W+STAMP_W+CNT_W+DELTA_W-1:
                                      2*POS_W+STAMP_W+CNT_W];
               state_in   = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_IDLE;
            case (func_ff)
               FUNC_DOWN: begin
                  start_px_in     = px_ff;
                  start_py_in     = py_ff;
                  start_stamp_in  = stamp_ff;
                  touch_active_in = 1'b1;
                  if (finger_count_ff != CNT_MAX) begin
                     finger_count_in = finger_count_ff + 1'b1;
                  end
               end
               FUNC_MOTION: begin
                  // hold needs a single finger pressed past the tap time
                  if (touch_active_ff && (finger_count_ff == CNT_W'(1)) && is_long) begin
                     start_px_in = px_ff;
                     start_py_in = py_ff;
                     res_g_in    = G_HOLD;
                     state_in    = S_DONE;
                  end
               end
               FUNC_UP: begin
                  if (finger_count_ff != '0) begin
                     finger_count_in = finger_count_ff - 1'b1;
                  end
                  if (touch_active_ff) begin
                     touch_active_in = 1'b0;
                     short_in        = is_short;
                     sq_cnt_in       = SQCNT_W'(SQ_W);
                     mx_in           = SQ_W'(dx);
                     my_in           = SQ_W'(dy);
                     mr_in           = SQ_W'(tap_radius_ff);
                     ms_in           = SQ_W'(swipe_min_ff);
                     ax_in           = PROD_W'(dx);
                     ay_in           = PROD_W'(dy);
                     ar_in           = PROD_W'(tap_radius_ff);
                     as_in           = PROD_W'(swipe_min_ff);
                     d2_in           = '0;
                     r2_in           = '0;
                     s2_in           = '0;
                     state_in        = S_CALC;
                  end
               end
               FUNC_MULTI: begin
                  if (fingers_ff == PINCH_FINGERS) begin
                     res_g_in = G_PINCH;
                     state_in = S_DONE;
                  end
               end
               default: ;
            endcase
         end

         S_CALC: begin
            if (sq_cnt_ff != '0) begin
               // shift-add squaring, one multiplier bit per cycle
               sq_cnt_in = sq_cnt_ff - 1'b1;
               d2_in = d2_ff + (mx_ff[0] ? D2_W'(ax_ff) : '0)
                             + (my_ff[0] ? D2_W'(ay_ff) : '0);
               r2_in = r2_ff + (mr_ff[0] ? ar_ff : '0);
               s2_in = s2_ff + (ms_ff[0] ? as_ff : '0);
               mx_in = mx_ff >> 1;
               my_in = my_ff >> 1;
               mr_in = mr_ff >> 1;
               ms_in = ms_ff >> 1;
               ax_in = ax_ff << 1;
               ay_in = ay_ff << 1;
               ar_in = ar_ff << 1;
               as_in = as_ff << 1;
            end else if (div_done_x) begin
               // tap is tested before swipe
               state_in = S_IDLE;
               if (short_ff && (d2_ff < D2_W'(r2_ff))) begin
                  res_g_in = G_TAP;
                  state_in = S_DONE;
               end else if (short_ff && (d2_ff >= D2_W'(s2_ff))) begin
                  res_g_in = G_SWIPE;
                  state_in = S_DONE;
               end
            end
         end

         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_gesture_in = res_g_ff;
               rsp_vel_x_in   = (res_g_ff == G_SWIPE) ? vel_x : '0;
               rsp_vel_y_in   = (res_g_ff == G_SWIPE) ? vel_y : '0;
               // a closing pinch reports zero
               rsp_pinch_in   = ((res_g_ff == G_PINCH) && !delta_ff[DELTA_W-1]) ?
                                delta_ff : '0;
               rsp_held_in    = finger_count_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         tap_time_ff     <= TAP_TIME_RST;
         tap_radius_ff   <= TAP_RADIUS_RST;
         swipe_min_ff    <= SWIPE_MIN_RST;
         touch_active_ff <= 1'b0;
         start_px_ff     <= '0;
         start_py_ff     <= '0;
         start_stamp_ff  <= '0;
         finger_count_ff <= '0;
         sq_cnt_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         tap_time_ff     <= tap_time_in;
         tap_radius_ff   <= tap_radius_in;
         swipe_min_ff    <= swipe_min_in;
         touch_active_ff <= touch_active_in;
         start_px_ff     <= start_px_in;
         start_py_ff     <= start_py_in;
         start_stamp_ff  <= start_stamp_in;
         finger_count_ff <= finger_count_in;
         sq_cnt_ff       <= sq_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      px_ff          <= px_in;
      py_ff          <= py_in;
      stamp_ff       <= stamp_in;
      fingers_ff     <= fingers_in;
      delta_ff       <= delta_in;
      short_ff       <= short_in;
      mx_ff          <= mx_in;
      my_ff          <= my_in;
      mr_ff          <= mr_in;
      ms_ff          <= ms_in;
      ax_ff          <= ax_in;
      ay_ff          <= ay_in;
      ar_ff          <= ar_in;
      as_ff          <= as_in;
      d2_ff          <= d2_in;
      r2_ff          <= r2_in;
      s2_ff          <= s2_in;
      res_g_ff       <= res_g_in;
      rsp_gesture_ff <= rsp_gesture_in;
      rsp_vel_x_ff   <= rsp_vel_x_in;
      rsp_vel_y_ff   <= rsp_vel_y_in;
      rsp_pinch_ff   <= rsp_pinch_in;
      rsp_held_ff    <= rsp_held_in;
   end

   // response ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_gesture_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 2*VEL_W - DELTA_W - CNT_W){1'b0}},
                        rsp_held_ff, rsp_pinch_ff, rsp_vel_y_ff, rsp_vel_x_ff};

   // checks
   `TGC_ASSERT_IMPL(a_calc_touch_clear, clock, reset, state_ff == S_CALC, !touch_active_ff)
   `TGC_ASSERT_IMPL(a_div_lockstep, clock, reset, 1'b1, div_done_x == div_done_y)
   `TGC_ASSERT_IMPL(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE))
   `TGC_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_fire, state_ff == S_EXEC)

endmodule

`default_nettype wire
